// ----- rtl/core/renc_q15_pkg.sv -----
package renc_q15_pkg;

  // Item kinds
  localparam logic [1:0] KIND_CDF    = 2'd0;
  localparam logic [1:0] KIND_BIT    = 2'd1;
  localparam logic [1:0] KIND_EQUI   = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  // Default parameter values
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int FF_RUN_MAX_DEF  = 48;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Coder constants
  localparam logic [15:0]        RANGE_RESET = 16'h8000;
  localparam logic [6:0]         PEND_RESET  = 7'h77;      // -9
  localparam logic [15:0]        MIN_PROB    = 16'd4;
  localparam logic [63:0]        ROUND_MASK  = 64'h3FFF;
  localparam logic [63:0]        FINISH_BIT  = 64'h4000;
  localparam logic signed [7:0]  FLUSH_AT    = 8'sd40;
  localparam logic signed [7:0]  WIN_OFF     = 8'sd24;
  localparam logic signed [7:0]  FIN_OFF     = 8'sd9;
  localparam logic [7:0]         BYTE_FF     = 8'hFF;

  // Byte batch handed from the interval front end to the byte release unit.
  // Bytes are packed most significant first: byte j of the batch, counted from the
  // least significant end, sits at bytes[8*j +: 8].
  typedef struct packed {
    logic        fin;
    logic        carry;
    logic [2:0]  nbytes;
    logic [55:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        end_of_stream;
    logic [23:0] stream_bytes;
    logic        run_overflow;
  } out_rec_t;

endpackage

// ----- rtl/core/range_encoder_cdf_q15_top.sv -----
// Q15 multi-symbol range encoder. Each request encodes one symbol (cdf bounds,
// a bit with a Q15 probability of one, or an equiprobable bit) or, with kind 3,
// closes the stream, releases every byte still held and returns to the reset state.
// Coded bytes come out in stream order with carries already resolved; last_of_run
// marks the final byte a request releases, and end_of_stream with stream_bytes
// marks the final byte of the stream. run_overflow is sticky until the next finish.
// The front end narrows the interval for a request in its idle state and renormalizes
// in its second state; it takes no new request until that is done, and it stalls
// there while its 2-entry batch queue is full. A request that moves no bytes out of
// the window never reaches the byte release unit. The byte release unit sets the
// sustained rate: it takes one batch at a time and releases each carried byte, each
// byte moved out of the window (up to 7) and each released 0xFF run byte in turn.
module range_encoder_cdf_q15_top #(
  parameter int MAX_SYMBOLS = renc_q15_pkg::MAX_SYMBOLS_DEF,
  parameter int FF_RUN_MAX  = renc_q15_pkg::FF_RUN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [3:0]  symbol,
  input  logic [4:0]  num_symbols,
  input  logic [15:0] upper_icdf,
  input  logic [15:0] lower_icdf,
  input  logic        bit_value,
  input  logic [15:0] prob_one,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        end_of_stream,
  output logic [23:0] stream_bytes,
  output logic        run_overflow
);

  localparam int CMD_W = $bits(renc_q15_pkg::cmd_t);
  localparam int OUT_W = $bits(renc_q15_pkg::out_rec_t);

  logic                    cmd_push;
  logic                    cmd_full;
  logic                    cmd_empty;
  logic                    cmd_pop;
  renc_q15_pkg::cmd_t      cmd_wr;
  logic [CMD_W-1:0]        cmd_rd_bits;
  renc_q15_pkg::cmd_t      cmd_rd;
  logic                    rec_push;
  logic                    rec_full;
  renc_q15_pkg::out_rec_t  rec_wr;
  logic [OUT_W-1:0]        rec_rd_bits;
  renc_q15_pkg::out_rec_t  rec_rd;

  renc_q15_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .symbol      (symbol),
    .num_symbols (num_symbols),
    .upper_icdf  (upper_icdf),
    .lower_icdf  (lower_icdf),
    .bit_value   (bit_value),
    .prob_one    (prob_one),
    .cmd_push    (cmd_push),
    .cmd         (cmd_wr),
    .cmd_full    (cmd_full)
  );

  renc_q15_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (renc_q15_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (CMD_W'(cmd_wr)),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_bits),
    .empty   (cmd_empty)
  );

  assign cmd_rd = renc_q15_pkg::cmd_t'(cmd_rd_bits);

  renc_q15_back #(
    .FF_RUN_MAX (FF_RUN_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_in    (cmd_rd),
    .cmd_pop   (cmd_pop),
    .out_push  (rec_push),
    .out_rec   (rec_wr),
    .out_full  (rec_full)
  );

  renc_q15_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (renc_q15_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (OUT_W'(rec_wr)),
    .full    (rec_full),
    .rd_en   (pop),
    .rd_data (rec_rd_bits),
    .empty   (empty)
  );

  // Unpack the oldest result onto the ports
  assign rec_rd        = renc_q15_pkg::out_rec_t'(rec_rd_bits);
  assign out_byte      = rec_rd.out_byte;
  assign last_of_run   = rec_rd.last_of_run;
  assign end_of_stream = rec_rd.end_of_stream;
  assign stream_bytes  = rec_rd.stream_bytes;
  assign run_overflow  = rec_rd.run_overflow;

endmodule

// ----- rtl/core/renc_q15_fifo.sv -----
module renc_q15_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/renc_q15_front.sv -----
module renc_q15_front #(
  parameter int MAX_SYMBOLS = renc_q15_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind,
  input  logic [3:0]          symbol,
  input  logic [4:0]          num_symbols,
  input  logic [15:0]         upper_icdf,
  input  logic [15:0]         lower_icdf,
  input  logic                bit_value,
  input  logic [15:0]         prob_one,
  output logic                cmd_push,
  output renc_q15_pkg::cmd_t  cmd,
  input  logic                cmd_full
);

  typedef enum logic {S_IDLE, S_NORM} state_t;

  state_t      state;
  logic [63:0] coder_low;
  logic [15:0] coder_range;
  logic [6:0]  pend;
  logic        fin;

  logic [7:0]  rhi;
  logic [4:0]  ns;
  logic [15:0] temp;
  logic [17:0] pu;
  logic [17:0] pl;
  logic [17:0] pf;
  logic [15:0] u;
  logic [15:0] v;
  logic [15:0] rb;
  logic [15:0] add_val;
  logic [15:0] r_calc;
  logic [63:0] l_calc;

  logic [3:0]         d;
  logic signed [7:0]  c8;
  logic signed [7:0]  s8;
  logic signed [7:0]  cc8;
  logic signed [7:0]  t8;
  logic signed [7:0]  sh8;
  logic [2:0]         nn;
  logic [2:0]         nf;
  logic [2:0]         nb;
  logic               flush;
  logic               need_push;
  logic [63:0]        e;
  logic [63:0]        src;
  logic [3:0]         amt;
  logic [63:0]        shv;
  logic [63:0]        mask;
  logic [63:0]        low_next;

  function automatic logic [3:0] lead_zeros(input logic [15:0] r);
    logic [3:0] z;
    z = 4'd15;
    for (int i = 0; i < 16; i++) begin
      if (r[i]) z = 4'(15 - i);
    end
    return z;
  endfunction

  assign full = (state != S_IDLE);

  // Narrow the interval for the incoming symbol
  always_comb begin
    rhi     = coder_range[15:8];
    ns      = (num_symbols > 5'(MAX_SYMBOLS)) ? 5'(MAX_SYMBOLS) : num_symbols;
    temp    = (16'(ns) - 16'd1 - 16'(symbol)) << 2;
    pu      = 18'(rhi) * 18'(upper_icdf[15:6]);
    pl      = 18'(rhi) * 18'(lower_icdf[15:6]);
    pf      = 18'(rhi) * 18'(prob_one[15:6]);
    u       = 16'(pu >> 1) + temp + renc_q15_pkg::MIN_PROB;
    v       = (kind == renc_q15_pkg::KIND_BIT) ? 16'(pf >> 1) + renc_q15_pkg::MIN_PROB
                                              : 16'({rhi, 7'd0}) + renc_q15_pkg::MIN_PROB;
    rb      = coder_range - v;
    add_val = '0;
    r_calc  = coder_range;
    unique case (kind)
      renc_q15_pkg::KIND_CDF: begin
        if (symbol != 4'd0) begin
          add_val = coder_range - u;
          r_calc  = u - 16'(pl >> 1) - temp;
        end else begin
          r_calc  = coder_range - 16'(pl >> 1) - temp;
        end
      end
      renc_q15_pkg::KIND_BIT, renc_q15_pkg::KIND_EQUI: begin
        if (bit_value) begin
          add_val = rb;
          r_calc  = v;
        end else begin
          r_calc  = rb;
        end
      end
      renc_q15_pkg::KIND_FINISH: begin
        r_calc = coder_range;
      end
    endcase
    l_calc = coder_low + 64'(add_val);
  end

  // Renormalize, or build the closing bytes of the stream
  always_comb begin
    d         = lead_zeros(coder_range);
    c8        = {pend[6], pend};
    s8        = c8 + $signed({4'd0, d});
    flush     = (s8 >= renc_q15_pkg::FLUSH_AT);
    nn        = s8[5:3] + 3'd1;
    cc8       = c8 + renc_q15_pkg::WIN_OFF - $signed({2'b00, nn, 3'b000});
    t8        = c8 + renc_q15_pkg::FIN_OFF;
    nf        = t8[5:3] + 3'd1;
    sh8       = c8 + renc_q15_pkg::WIN_OFF - $signed({2'b00, nf, 3'b000});
    e         = ((coder_low + renc_q15_pkg::ROUND_MASK) & ~renc_q15_pkg::ROUND_MASK)
                | renc_q15_pkg::FINISH_BIT;
    src       = fin ? e : coder_low;
    amt       = fin ? sh8[3:0] : cc8[3:0];
    shv       = src >> amt;
    nb        = fin ? nf : (flush ? nn : 3'd0);
    mask      = (64'd1 << cc8[3:0]) - 64'd1;
    low_next  = (flush ? (coder_low & mask) : coder_low) << d;
    need_push = fin || flush;
    cmd.fin    = fin;
    cmd.nbytes = nb;
    cmd.bytes  = shv[55:0];
    cmd.carry  = shv[{nb, 3'b000}];
    cmd_push   = (state == S_NORM) && need_push && !cmd_full;
  end

  // Hold coder state and step through accept and renormalize
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      coder_low   <= '0;
      coder_range <= renc_q15_pkg::RANGE_RESET;
      pend        <= renc_q15_pkg::PEND_RESET;
      fin         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            coder_low   <= l_calc;
            coder_range <= r_calc;
            fin         <= (kind == renc_q15_pkg::KIND_FINISH);
            state       <= S_NORM;
          end
        end
        S_NORM: begin
          if (!(need_push && cmd_full)) begin
            if (fin) begin
              coder_low   <= '0;
              coder_range <= renc_q15_pkg::RANGE_RESET;
              pend        <= renc_q15_pkg::PEND_RESET;
            end else begin
              coder_low   <= low_next;
              coder_range <= coder_range << d;
              pend        <= flush ? {4'b1111, s8[2:0]} : s8[6:0];
            end
            fin   <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/renc_q15_back.sv -----
module renc_q15_back #(
  parameter int FF_RUN_MAX = renc_q15_pkg::FF_RUN_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_empty,
  input  renc_q15_pkg::cmd_t      cmd_in,
  output logic                    cmd_pop,
  output logic                    out_push,
  output renc_q15_pkg::out_rec_t  out_rec,
  input  logic                    out_full
);

  localparam int RUN_W = $clog2(FF_RUN_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CARRY, S_CARRY_RUN, S_BYTE, S_REL_RUN, S_FIN, S_FIN_RUN, S_DONE
  } state_t;

  state_t              state;
  renc_q15_pkg::cmd_t  cmd;
  logic [2:0]          k;
  logic [7:0]          held_byte;
  logic                held_valid;
  logic [RUN_W-1:0]    run_len;
  logic [23:0]         total;
  logic                ovf;
  logic                stage_valid;
  logic [7:0]          stage_byte;

  logic                can_emit;
  logic                emit_en;
  logic [7:0]          emit_byte;
  logic [2:0]          cur_idx;
  logic [7:0]          cur_byte;
  logic                at_end;
  logic                final_flush;

  // Replay the byte batch on a copy of the run state to get the item's overflow flag
  function automatic logic item_ovf(input logic hv_in, input logic [RUN_W-1:0] run_in,
                                    input logic ovf_in, input renc_q15_pkg::cmd_t c);
    logic             hv;
    logic [RUN_W-1:0] rn;
    logic             o;
    logic [2:0]       idx;
    logic [7:0]       b;
    hv  = hv_in;
    rn  = run_in;
    o   = ovf_in;
    idx = '0;
    b   = '0;
    if (c.carry && hv) begin
      hv = 1'b0;
      rn = '0;
    end
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < c.nbytes) begin
        idx = c.nbytes - 3'd1 - 3'(i);
        b   = c.bytes[{idx, 3'b000} +: 8];
        if (!hv) begin
          hv = 1'b1;
        end else if (b == renc_q15_pkg::BYTE_FF) begin
          if (rn < RUN_W'(FF_RUN_MAX)) rn = rn + 1'b1;
          else o = 1'b1;
        end else begin
          rn = '0;
        end
      end
    end
    return o;
  endfunction

  assign can_emit    = !stage_valid || !out_full;
  assign cur_idx     = cmd.nbytes - 3'd1 - k;
  assign cur_byte    = cmd.bytes[{cur_idx, 3'b000} +: 8];
  assign at_end      = (k == cmd.nbytes);
  assign cmd_pop     = (state == S_IDLE) && !cmd_empty;
  assign final_flush = (state == S_DONE) && stage_valid && !out_full;

  // Pick the byte released this cycle
  always_comb begin
    emit_en   = 1'b0;
    emit_byte = '0;
    unique case (state)
      S_CARRY: begin
        emit_en   = held_valid && can_emit;
        emit_byte = held_byte + 8'd1;
      end
      S_CARRY_RUN: begin
        emit_en   = can_emit;
        emit_byte = 8'h00;
      end
      S_BYTE: begin
        emit_en   = !at_end && held_valid && (cur_byte != renc_q15_pkg::BYTE_FF) && can_emit;
        emit_byte = held_byte;
      end
      S_REL_RUN, S_FIN_RUN: begin
        emit_en   = can_emit;
        emit_byte = renc_q15_pkg::BYTE_FF;
      end
      S_FIN: begin
        emit_en   = held_valid && can_emit;
        emit_byte = held_byte;
      end
      S_IDLE, S_DONE: begin
        emit_en = 1'b0;
      end
    endcase
  end

  // Move the staged byte out; mark it last when the item is done
  always_comb begin
    out_push              = stage_valid && (emit_en || final_flush);
    out_rec.out_byte      = stage_byte;
    out_rec.last_of_run   = (state == S_DONE);
    out_rec.end_of_stream = (state == S_DONE) && cmd.fin;
    out_rec.stream_bytes  = ((state == S_DONE) && cmd.fin) ? total : '0;
    out_rec.run_overflow  = ovf;
  end

  // Sequence carry, byte pushes and final release
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      k           <= '0;
      held_valid  <= 1'b0;
      run_len     <= '0;
      total       <= '0;
      ovf         <= 1'b0;
      stage_valid <= 1'b0;
    end else begin
      if (emit_en) begin
        stage_byte  <= emit_byte;
        stage_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd   <= cmd_in;
            k     <= '0;
            total <= total + 24'(cmd_in.nbytes);
            ovf   <= item_ovf(held_valid, run_len, ovf, cmd_in);
            state <= cmd_in.carry ? S_CARRY : S_BYTE;
          end
        end
        S_CARRY: begin
          if (!held_valid) begin
            state <= S_BYTE;
          end else if (can_emit) begin
            if (run_len == '0) begin
              held_valid <= 1'b0;
              state      <= S_BYTE;
            end else begin
              state <= S_CARRY_RUN;
            end
          end
        end
        S_CARRY_RUN: begin
          if (can_emit) begin
            run_len <= run_len - 1'b1;
            if (run_len == RUN_W'(1)) begin
              held_valid <= 1'b0;
              state      <= S_BYTE;
            end
          end
        end
        S_BYTE: begin
          if (at_end) begin
            state <= cmd.fin ? S_FIN : S_DONE;
          end else if (!held_valid) begin
            held_byte  <= cur_byte;
            held_valid <= 1'b1;
            k          <= k + 3'd1;
          end else if (cur_byte == renc_q15_pkg::BYTE_FF) begin
            if (run_len < RUN_W'(FF_RUN_MAX)) run_len <= run_len + 1'b1;
            k <= k + 3'd1;
          end else if (can_emit) begin
            held_byte <= cur_byte;
            k         <= k + 3'd1;
            if (run_len != '0) state <= S_REL_RUN;
          end
        end
        S_REL_RUN: begin
          if (can_emit) begin
            run_len <= run_len - 1'b1;
            if (run_len == RUN_W'(1)) state <= S_BYTE;
          end
        end
        S_FIN: begin
          if (!held_valid) begin
            state <= S_DONE;
          end else if (can_emit) begin
            if (run_len == '0) begin
              held_valid <= 1'b0;
              state      <= S_DONE;
            end else begin
              state <= S_FIN_RUN;
            end
          end
        end
        S_FIN_RUN: begin
          if (can_emit) begin
            run_len <= run_len - 1'b1;
            if (run_len == RUN_W'(1)) begin
              held_valid <= 1'b0;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!stage_valid || !out_full) begin
            stage_valid <= 1'b0;
            if (cmd.fin) begin
              held_byte  <= '0;
              held_valid <= 1'b0;
              run_len    <= '0;
              total      <= '0;
              ovf        <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_len <= RUN_W'(FF_RUN_MAX))
    else $error("ff run exceeds its bound");
  a_run_needs_held: assert property (@(posedge clk) disable iff (rst)
    !held_valid |-> (run_len == '0))
    else $error("ff run pending with no held byte");
  a_idle_stage_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !stage_valid)
    else $error("staged byte left over between items");
`endif

endmodule
